// ----- src/ctrie_pkg.sv -----
// Shared types and constants for the counting prefix trie.
`default_nettype none

package ctrie_pkg;

  localparam int LETTER_W    = 5;
  localparam int COUNT_OUT_W = 16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_EXACT  = 2'd1,
    KIND_PREFIX = 2'd2,
    KIND_ERASE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // One input letter item
  typedef struct packed {
    kind_e                 kind;
    logic [LETTER_W-1:0]   letter;
    logic                  has_letter;
    logic                  end_of_word;
  } item_t;

  // One result item
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    status_e                status;
  } res_t;

endpackage

`default_nettype wire

// ----- src/counting_prefix_trie.sv -----
// Top level of the counting prefix trie: stream ports, RAMs and output register.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  letter, kind, has_letter, end_of_word
//  m_axis    out  m_axis_tvalid/m_axis_tready  count, status (end of word only)
//
// Steps per item: a letter of a count query is accepted with a child RAM read,
// then its child is checked; an insert or erase letter adds a count RAM
// read-modify-write. A closing item adds the count update and a step that loads
// the output register; a bare end of word skips the child steps, and after a
// failure only the output load is left. The child RAM read is registered.
// After reset a clearing pass zeroes both RAMs, during which s_axis_tready
// stays low. A stalled output holds the sequencer only when a new result is
// ready; letters keep flowing while a result waits.
`default_nettype none

module counting_prefix_trie
  import ctrie_pkg::*;
#(
  parameter int NODES       = 1024,
  parameter int ALPHABET    = 26,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  wire logic [2:0]  s_axis_tuser,   // [1:0] kind, [2] has_letter
  input  wire logic        s_axis_tlast,   // end_of_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] count
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  localparam int NW = $clog2(NODES);
  localparam int AW = $clog2(NODES * ALPHABET);
  localparam int CW = COUNT_WIDTH;

  item_t                item;
  res_t                 res;
  logic                 res_valid;
  logic                 out_free;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q;

  logic [AW-1:0]        child_addr;
  logic                 child_we, child_re;
  logic [NW-1:0]        child_wdata, child_rdata;
  logic [NW-1:0]        cnt_addr;
  logic                 cnt_we, cnt_re;
  logic [2*CW-1:0]      cnt_wdata, cnt_rdata;

  // Unpack the input transfer
  assign item.kind        = kind_e'(s_axis_tuser[1:0]);
  assign item.letter      = s_axis_tdata[LETTER_W-1:0];
  assign item.has_letter  = s_axis_tuser[2];
  assign item.end_of_word = s_axis_tlast;

  // Output register frees up in the same cycle its result is taken
  assign out_free = !out_valid_q || m_axis_tready;

  ctrie_ctrl #(
    .NODES      (NODES),
    .ALPHABET   (ALPHABET),
    .COUNT_WIDTH(COUNT_WIDTH),
    .NW         (NW),
    .AW         (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .item_i       (item),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .child_addr_o (child_addr),
    .child_we_o   (child_we),
    .child_re_o   (child_re),
    .child_wdata_o(child_wdata),
    .child_rdata_i(child_rdata),
    .cnt_addr_o   (cnt_addr),
    .cnt_we_o     (cnt_we),
    .cnt_re_o     (cnt_re),
    .cnt_wdata_o  (cnt_wdata),
    .cnt_rdata_i  (cnt_rdata)
  );

  // Child table: one slot per node and letter, holding the child node index
  ctrie_ram #(
    .WIDTH(NW),
    .DEPTH(NODES * ALPHABET)
  ) u_child_ram (
    .clk_i  (clk_i),
    .we_i   (child_we),
    .re_i   (child_re),
    .addr_i (child_addr),
    .wdata_i(child_wdata),
    .rdata_o(child_rdata)
  );

  // Count table: end count in the upper half, prefix count in the lower half
  ctrie_ram #(
    .WIDTH(2 * CW),
    .DEPTH(NODES)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .re_i   (cnt_re),
    .addr_i (cnt_addr),
    .wdata_i(cnt_wdata),
    .rdata_o(cnt_rdata)
  );

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.count;
  assign m_axis_tuser  = out_q.status;

endmodule

`default_nettype wire

// ----- src/ctrie_ram.sv -----
// Single-port synchronous RAM with registered read data.
`default_nettype none

module ctrie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/ctrie_ctrl.sv -----
// Sequencer that walks, allocates and counts trie nodes in the two RAMs.
`default_nettype none

module ctrie_ctrl
  import ctrie_pkg::*;
#(
  parameter int NODES       = 1024,
  parameter int ALPHABET    = 26,
  parameter int COUNT_WIDTH = 16,
  parameter int NW          = $clog2(NODES),
  parameter int AW          = $clog2(NODES * ALPHABET)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire item_t                    item_i,
  input  wire logic                     out_free_i,
  output logic                          res_valid_o,
  output res_t                          res_o,
  output logic [AW-1:0]                 child_addr_o,
  output logic                          child_we_o,
  output logic                          child_re_o,
  output logic [NW-1:0]                 child_wdata_o,
  input  wire logic [NW-1:0]            child_rdata_i,
  output logic [NW-1:0]                 cnt_addr_o,
  output logic                          cnt_we_o,
  output logic                          cnt_re_o,
  output logic [2*COUNT_WIDTH-1:0]      cnt_wdata_o,
  input  wire logic [2*COUNT_WIDTH-1:0] cnt_rdata_i
);

  localparam int CW = COUNT_WIDTH;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_CHILD  = 5'b00100,
    S_COUNT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [NW-1:0]  cur_q, cur_d;
  logic [NW:0]    free_q, free_d;
  status_e        fail_q, fail_d;
  kind_e          kind_q, kind_d;
  logic           eow_q, eow_d;
  logic           walked_q, walked_d;
  logic [AW-1:0]  slot_q, slot_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [NW-1:0]  node_q, node_d;
  res_t           res_q, res_d;

  logic [AW-1:0]  slot_addr;
  logic           letter_ok;
  logic           accept;
  logic [CW-1:0]  end_v, pfx_v, end_n, pfx_n, cnt_sel;
  logic [CW+COUNT_OUT_W-1:0] cnt_ext;

  assign slot_addr = AW'(cur_q) * AW'(ALPHABET) + AW'(item_i.letter);
  assign letter_ok = {{(32-LETTER_W){1'b0}}, item_i.letter} < 32'(ALPHABET);
  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  assign end_v = cnt_rdata_i[2*CW-1:CW];
  assign pfx_v = cnt_rdata_i[CW-1:0];

  // Saturating prefix and end count updates for the node just read
  always_comb begin
    pfx_n = pfx_v;
    end_n = end_v;
    if (walked_q) begin
      if (kind_q == KIND_INSERT) begin
        pfx_n = (pfx_v == {CW{1'b1}}) ? pfx_v : pfx_v + 1'b1;
      end else if (kind_q == KIND_ERASE) begin
        pfx_n = (pfx_v == '0) ? pfx_v : pfx_v - 1'b1;
      end
    end
    if (eow_q) begin
      if (kind_q == KIND_INSERT) begin
        end_n = (end_v == {CW{1'b1}}) ? end_v : end_v + 1'b1;
      end else if (kind_q == KIND_ERASE) begin
        end_n = (end_v == '0) ? end_v : end_v - 1'b1;
      end
    end
    case (kind_q)
      KIND_EXACT:  cnt_sel = end_v;
      KIND_PREFIX: cnt_sel = pfx_n;
      default:     cnt_sel = end_n;
    endcase
  end

  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_sel};

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    free_d        = free_q;
    fail_d        = fail_q;
    kind_d        = kind_q;
    eow_d         = eow_q;
    walked_d      = walked_q;
    slot_d        = slot_q;
    clr_d         = clr_q;
    node_d        = node_q;
    res_d         = res_q;
    child_addr_o  = slot_addr;
    child_we_o    = 1'b0;
    child_re_o    = 1'b0;
    child_wdata_o = '0;
    cnt_addr_o    = cur_q;
    cnt_we_o      = 1'b0;
    cnt_re_o      = 1'b0;
    cnt_wdata_o   = {end_n, pfx_n};
    res_valid_o   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // Zero every child slot, and the count entries on the way
        child_addr_o = clr_q;
        child_we_o   = 1'b1;
        cnt_addr_o   = clr_q[NW-1:0];
        cnt_we_o     = 1'b1;
        cnt_wdata_o  = '0;
        clr_d        = clr_q + 1'b1;
        if (clr_q == AW'(NODES * ALPHABET - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_d   = item_i.kind;
          eow_d    = item_i.end_of_word;
          slot_d   = slot_addr;
          walked_d = 1'b0;
          res_d    = '{count: '0, status: fail_q};
          if (item_i.has_letter && fail_q == ST_OK && letter_ok) begin
            child_re_o = 1'b1;
            state_d    = S_CHILD;
          end else if (item_i.has_letter && fail_q == ST_OK) begin
            fail_d = ST_MISS;
            res_d  = '{count: '0, status: ST_MISS};
            if (item_i.end_of_word) begin
              state_d = S_FINISH;
            end
          end else if (item_i.end_of_word) begin
            if (fail_q == ST_OK) begin
              cnt_re_o = 1'b1;
              node_d   = cur_q;
              state_d  = S_COUNT;
            end else begin
              state_d = S_FINISH;
            end
          end
        end
      end
      S_CHILD: begin
        if (child_rdata_i == '0 && kind_q != KIND_INSERT) begin
          fail_d  = ST_MISS;
          res_d   = '{count: '0, status: ST_MISS};
          state_d = eow_q ? S_FINISH : S_IDLE;
        end else if (child_rdata_i == '0 && free_q >= (NW+1)'(NODES)) begin
          fail_d  = ST_FULL;
          res_d   = '{count: '0, status: ST_FULL};
          state_d = eow_q ? S_FINISH : S_IDLE;
        end else begin
          if (child_rdata_i == '0) begin
            // Allocate the next free node into this slot
            child_addr_o  = slot_q;
            child_we_o    = 1'b1;
            child_wdata_o = free_q[NW-1:0];
            free_d        = free_q + 1'b1;
            node_d        = free_q[NW-1:0];
          end else begin
            node_d = child_rdata_i;
          end
          cur_d      = node_d;
          cnt_addr_o = node_d;
          if (kind_q == KIND_INSERT || kind_q == KIND_ERASE || eow_q) begin
            cnt_re_o = 1'b1;
            walked_d = 1'b1;
            state_d  = S_COUNT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_COUNT: begin
        cnt_addr_o = node_q;
        cnt_we_o   = 1'b1;
        res_d      = '{count: cnt_ext[COUNT_OUT_W-1:0], status: ST_OK};
        state_d    = eow_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          cur_d       = '0;
          fail_d      = ST_OK;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= '0;
      free_q  <= (NW+1)'(1);
      fail_q  <= ST_OK;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      fail_q  <= fail_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    eow_q    <= eow_d;
    walked_q <= walked_d;
    slot_q   <= slot_d;
    node_q   <= node_d;
    res_q    <= res_d;
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= (NW+1)'(NODES))
    else $error("free node pointer beyond pool");

  a_cur_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NW+1)'(cur_q) < free_q)
    else $error("current node not allocated");

  a_child_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(child_we_o && child_re_o))
    else $error("child RAM read and write in one cycle");

  a_no_walk_after_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHILD || state_q == S_COUNT) |-> fail_q == ST_OK)
    else $error("walk continued after a failed letter");

  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !out_free_i) |=> state_q == S_FINISH)
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the counting prefix trie stream block.
`default_nettype none

module tb_top import ctrie_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES    = 1024;
  localparam int ALPHABET = 26;

  // Shadow copy of the trie: follows every accepted letter transfer and queues the
  // answer each closing transfer must produce, then compares it with the block's
  // result transfers in order.
  class trie_tracker;
    bit [9:0]    child_of [NODES*ALPHABET];
    bit [15:0]   end_cnt  [NODES];
    bit [15:0]   pass_cnt [NODES];
    int unsigned next_free;
    int unsigned cur_node;
    status_e     word_fail;
    res_t        expected_q[$];
    int          mismatches;
    int          results_seen;
    int          items_seen;
    int          words_seen;
    int          miss_count;
    int          full_count;

    function new();
      next_free    = 1;
      cur_node     = 0;
      word_fail    = ST_OK;
      mismatches   = 0;
      results_seen = 0;
      items_seen   = 0;
      words_seen   = 0;
      miss_count   = 0;
      full_count   = 0;
    endfunction

    static function bit [15:0] bump_up(bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    static function bit [15:0] bump_down(bit [15:0] v);
      return (v == 16'd0) ? v : v - 16'd1;
    endfunction

    // Step one letter down the trie; allocate on insert, flag a miss or a full pool.
    function void follow_letter(kind_e k, int unsigned letter);
      int unsigned slot;
      int unsigned child;
      if (letter >= ALPHABET) begin
        word_fail = ST_MISS;
        return;
      end
      slot  = cur_node * ALPHABET + letter;
      child = child_of[slot];
      if (child == 0) begin
        if (k != KIND_INSERT) begin
          word_fail = ST_MISS;
          return;
        end
        if (next_free >= NODES) begin
          word_fail = ST_FULL;
          return;
        end
        child          = next_free;
        next_free      = next_free + 1;
        child_of[slot] = child[9:0];
      end
      if (k == KIND_INSERT)
        pass_cnt[child] = bump_up(pass_cnt[child]);
      else if (k == KIND_ERASE)
        pass_cnt[child] = bump_down(pass_cnt[child]);
      cur_node = child;
    endfunction

    function void note_item(item_t it);
      res_t r;
      items_seen++;
      if (it.has_letter && word_fail == ST_OK)
        follow_letter(it.kind, it.letter);
      if (!it.end_of_word)
        return;
      words_seen++;
      r.status = word_fail;
      r.count  = '0;
      if (word_fail == ST_OK) begin
        case (it.kind)
          KIND_INSERT: begin
            end_cnt[cur_node] = bump_up(end_cnt[cur_node]);
            r.count = end_cnt[cur_node];
          end
          KIND_ERASE: begin
            end_cnt[cur_node] = bump_down(end_cnt[cur_node]);
            r.count = end_cnt[cur_node];
          end
          KIND_EXACT:  r.count = end_cnt[cur_node];
          default:     r.count = pass_cnt[cur_node];
        endcase
      end else if (word_fail == ST_MISS) begin
        miss_count++;
      end else begin
        full_count++;
      end
      expected_q.push_back(r);
      cur_node  = 0;
      word_fail = ST_OK;
    endfunction

    function void check_result(logic [15:0] cnt, logic [1:0] st);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: count=%0d status=%0d", $realtime, cnt, st);
        return;
      end
      want = expected_q.pop_front();
      if (cnt !== want.count || st !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d: expected count=%0d status=%0d, got count=%0d status=%0d",
                   $realtime, results_seen, want.count, want.status, cnt, st);
      end
    endfunction
  endclass

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = '0;
  logic [2:0]  s_user  = '0;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  wire logic        s_ready;
  wire logic        m_valid;
  wire logic [15:0] m_data;
  wire logic [1:0]  m_user;

  trie_tracker tracker = new();
  bit          quiet;
  int          drain_cycles;

  always #4 clk_i = ~clk_i;

  counting_prefix_trie u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),   // [4:0] letter, [7:5] zero
    .s_axis_tuser  (s_user),   // [1:0] kind, [2] has_letter
    .s_axis_tlast  (s_last),   // end_of_word
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),   // [15:0] count
    .m_axis_tuser  (m_user)    // [1:0] status
  );

  // Offer one letter transfer and hold it until the block takes it. Valid is left
  // high on return so a back-to-back item needs no second assignment in this step.
  task automatic send_item(kind_e k, logic [4:0] letter, logic has, logic eow);
    item_t it;
    int    gap;
    it.kind        = k;
    it.letter      = letter;
    it.has_letter  = has;
    it.end_of_word = eow;
    // Run a burst without gaps on either side every so often.
    quiet = ((tracker.items_seen / 40) % 6) == 5;
    gap   = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data  <= {3'b000, letter};
    s_user  <= {has, k};
    s_last  <= eow;
    s_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    tracker.note_item(it);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every queued answer has come back.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (tracker.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // One random word. Most are well formed over a tiny alphabet so paths are shared
  // and queries hit; long fresh inserts eat into the node pool; a few raw
  // transfers and bad letters break the sequences.
  task automatic random_word();
    int    r;
    int    len;
    bit    fresh;
    bit    trailing;
    kind_e k;
    kind_e ki;
    logic [4:0] ltr;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_item(kind_e'($urandom_range(0, 3)), 5'($urandom), 1'($urandom), 1'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 35)      k = KIND_INSERT;
    else if (r < 55) k = KIND_EXACT;
    else if (r < 75) k = KIND_PREFIX;
    else             k = KIND_ERASE;
    fresh = (k == KIND_INSERT) && ($urandom_range(0, 1) == 1);
    len   = fresh ? $urandom_range(10, 24) : $urandom_range(0, 4);
    if (len == 0) begin
      send_item(k, 5'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      ki  = ($urandom_range(0, 19) == 0) ? kind_e'($urandom_range(0, 3)) : k;
      ltr = fresh ? 5'($urandom_range(0, 25)) : 5'($urandom_range(0, 3));
      if ($urandom_range(0, 39) == 0)
        ltr = 5'($urandom_range(26, 31));
      trailing = (i == len - 1) && ($urandom_range(0, 19) == 0);
      send_item(ki, ltr, 1'b1, (i == len - 1) && !trailing);
      if (trailing)
        send_item(k, 5'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Result side: stall a random number of cycles before each transfer, then
  // compare whatever the block presents with the oldest queued answer.
  initial begin : result_sink
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
      tracker.check_result(m_data, m_user);
      @(negedge clk_i);
    end
  end

  // Hard stop: covers the clearing pass after reset and the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("[%0t] timeout with %0d answers outstanding", $realtime,
             tracker.expected_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty words on the root, saturation at zero, a two-letter path,
    // misses on query and erase, a bad letter, mixed kinds, a trailing empty item.
    send_item(KIND_PREFIX, 5'd0,  1'b0, 1'b1);  // root prefix count stays zero
    send_item(KIND_INSERT, 5'd31, 1'b0, 1'b1);  // empty word stored at the root
    send_item(KIND_EXACT,  5'd7,  1'b0, 1'b1);
    send_item(KIND_ERASE,  5'd0,  1'b0, 1'b1);
    send_item(KIND_ERASE,  5'd0,  1'b0, 1'b1);  // end count holds at zero
    send_item(KIND_INSERT, 5'd0,  1'b1, 1'b0);
    send_item(KIND_INSERT, 5'd25, 1'b1, 1'b1);
    send_item(KIND_PREFIX, 5'd0,  1'b1, 1'b1);
    send_item(KIND_EXACT,  5'd0,  1'b1, 1'b0);
    send_item(KIND_EXACT,  5'd25, 1'b1, 1'b1);
    send_item(KIND_EXACT,  5'd1,  1'b1, 1'b1);  // miss on query
    send_item(KIND_INSERT, 5'd31, 1'b1, 1'b1);  // letter out of range
    send_item(KIND_ERASE,  5'd0,  1'b1, 1'b0);
    send_item(KIND_ERASE,  5'd1,  1'b1, 1'b1);  // miss keeps the decrement on 'a'
    send_item(KIND_PREFIX, 5'd0,  1'b1, 1'b1);
    send_item(KIND_INSERT, 5'd0,  1'b1, 1'b0);  // mixed kinds within one word
    send_item(KIND_PREFIX, 5'd25, 1'b1, 1'b1);
    send_item(KIND_INSERT, 5'd0,  1'b1, 1'b0);
    send_item(KIND_EXACT,  5'd26, 1'b0, 1'b1);  // trailing empty item closes on 'a'
    send_item(KIND_ERASE,  5'd30, 1'b1, 1'b0);  // bad letter mid word, rest ignored
    send_item(KIND_ERASE,  5'd0,  1'b1, 1'b1);
    drain_results();

    // Random: about 1300 transfers in all, with one full drain halfway through.
    while (tracker.items_seen < 1300) begin
      random_word();
      if (!mid_pause_done && tracker.items_seen > 650) begin
        drain_results();
        mid_pause_done = 1'b1;
      end
    end
    s_valid <= 1'b0;

    drain_cycles = 0;
    while (tracker.expected_q.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (16) @(posedge clk_i);
    if (tracker.expected_q.size() != 0) begin
      $display("%0d answers never arrived", tracker.expected_q.size());
      tracker.mismatches += tracker.expected_q.size();
    end

    $display("covered %0d words in %0d letter transfers, %0d of %0d nodes allocated",
             tracker.words_seen, tracker.items_seen, tracker.next_free, NODES);
    $display("compared %0d results: %0d path misses, %0d pool-full answers, %0d mismatches",
             tracker.results_seen, tracker.miss_count, tracker.full_count,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/ctrie_pkg.sv
src/ctrie_ram.sv
src/ctrie_ctrl.sv
src/counting_prefix_trie.sv
tb/tb_top.sv
